/* rtl/xcrc_pkg.sv */
package xcrc_pkg;

	// default address width of the byte address counter
	localparam int ADDR_BITS_DEF = 16;

	// protocol characters
	localparam logic [7:0] CH_SOH   = 8'h01;
	localparam logic [7:0] CH_EOT   = 8'h04;
	localparam logic [7:0] CH_ACK   = 8'h06;
	localparam logic [7:0] CH_NAK   = 8'h15;
	localparam logic [7:0] CH_READY = 8'h43;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam int PAYLOAD_BYTES = 128;
	localparam int WORDS         = 16;
	localparam int WORD_IDX_W    = $clog2(WORDS);
	localparam int WORD_W        = 64;

	// input word kinds (carried on tuser)
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// output word kinds (carried on tuser)
	localparam logic KIND_HOST = 1'b0;
	localparam logic KIND_WORD = 1'b1;

	// configuration register map
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 17;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_CHECK_ENABLE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_READY_INTERVAL   = 1'b1;

	// command queue between front and back
	localparam int CMDQ_DEPTH = 2;

	typedef struct packed {
		logic       is_flush;
		logic [7:0] tx_byte;
	} cmd_t;

	typedef struct packed {
		logic                  we;
		logic [WORD_IDX_W-1:0] addr;
		logic [WORD_W-1:0]     data;
	} bufwr_t;

	// crc-16/xmodem over one byte, msb first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

/* rtl/xcrc_cmdq.sv */
module xcrc_cmdq
	import xcrc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head_cmd,
	output logic empty,
	output logic full
);

	localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

	cmd_t             slot_q [CMDQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(CMDQ_DEPTH));
	assign head_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("command queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("command queue underflow");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("command queue count did not advance");
`endif

endmodule

/* rtl/xcrc_front.sv */
module xcrc_front
	import xcrc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,
	input  logic                  s_tuser,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  q_full,
	output logic                  push,
	output cmd_t                  push_cmd,
	output bufwr_t                buf_wr,
	input  logic                  flush_done
);

	typedef enum logic [7:0] {
		PH_FIRST  = 8'b0000_0001,
		PH_HEADER = 8'b0000_0010,
		PH_BLOCK  = 8'b0000_0100,
		PH_COMPL  = 8'b0000_1000,
		PH_DATA   = 8'b0001_0000,
		PH_CRC_HI = 8'b0010_0000,
		PH_CRC_LO = 8'b0100_0000,
		PH_DONE   = 8'b1000_0000
	} phase_t;

	phase_t                  phase_q;
	logic                    crc_en_q;
	logic [CFG_DATA_W-1:0]   interval_q;
	logic [CFG_DATA_W-1:0]   countdown_q;
	logic [7:0]              exp_block_q;
	logic [6:0]              byte_idx_q;
	logic [15:0]             crc_q;
	logic [7:0]              crc_hi_q;
	logic [WORD_W-9:0]       asm_q;
	logic                    flush_busy_q;

	logic       accept;
	logic       is_byte;
	logic [7:0] b;
	logic       crc_bad;
	logic [2:0] lane;

	assign b       = s_tdata;
	assign is_byte = (s_tuser == OP_BYTE);
	assign lane    = byte_idx_q[2:0];
	assign crc_bad = crc_en_q && ({crc_hi_q, b} != crc_q);

	// data bytes wait while the buffer is still being drained
	assign s_tready = !q_full && !((phase_q == PH_DATA) && flush_busy_q);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		push     = 1'b0;
		push_cmd = '{is_flush: 1'b0, tx_byte: CH_NAK};
		if (accept) begin
			if (!is_byte) begin
				if (phase_q == PH_FIRST && countdown_q == '0) begin
					push     = 1'b1;
					push_cmd = '{is_flush: 1'b0, tx_byte: CH_READY};
				end
			end else begin
				unique case (phase_q)
					PH_HEADER: begin
						if (b == CH_EOT) begin
							push     = 1'b1;
							push_cmd = '{is_flush: 1'b0, tx_byte: CH_ACK};
						end
					end
					PH_BLOCK: begin
						push = (b != exp_block_q);
					end
					PH_CRC_LO: begin
						push     = 1'b1;
						push_cmd = '{is_flush: !crc_bad, tx_byte: crc_bad ? CH_NAK : CH_ACK};
					end
					PH_FIRST, PH_COMPL, PH_DATA, PH_CRC_HI, PH_DONE: begin
						push = 1'b0;
					end
					default: push = 1'b0;
				endcase
			end
		end
	end

	always_comb begin
		buf_wr.we   = accept && is_byte && (phase_q == PH_DATA) && (lane == 3'd7);
		buf_wr.addr = byte_idx_q[6:3];
		buf_wr.data = {b, asm_q};
	end

	always_ff @(posedge clk) begin
		if (accept && is_byte && phase_q == PH_DATA && lane != 3'd7) begin
			asm_q[8*lane +: 8] <= b;
		end
		if (accept && is_byte && phase_q == PH_CRC_HI) begin
			crc_hi_q <= b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_en_q   <= 1'b1;
			interval_q <= CFG_DATA_W'(65536);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CRC_CHECK_ENABLE: crc_en_q   <= cfg_data[0];
				REG_READY_INTERVAL:   interval_q <= cfg_data;
				default:              ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_FIRST;
			countdown_q  <= '0;
			exp_block_q  <= 8'd1;
			byte_idx_q   <= '0;
			crc_q        <= '0;
			flush_busy_q <= 1'b0;
		end else begin
			if (push && push_cmd.is_flush) begin
				flush_busy_q <= 1'b1;
			end else if (flush_done) begin
				flush_busy_q <= 1'b0;
			end
			if (accept && !is_byte) begin
				if (phase_q == PH_FIRST) begin
					if (countdown_q == '0) begin
						countdown_q <= (interval_q == '0) ? '0 : interval_q - 1'b1;
					end else begin
						countdown_q <= countdown_q - 1'b1;
					end
				end
			end else if (accept) begin
				unique case (phase_q)
					PH_FIRST: begin
						if (b == CH_SOH) begin
							phase_q <= PH_BLOCK;
						end
					end
					PH_HEADER: begin
						phase_q <= (b == CH_EOT) ? PH_DONE : PH_BLOCK;
					end
					PH_BLOCK: begin
						phase_q <= (b == exp_block_q) ? PH_COMPL : PH_HEADER;
					end
					PH_COMPL: begin
						if (b == ~exp_block_q) begin
							phase_q    <= PH_DATA;
							byte_idx_q <= '0;
							crc_q      <= '0;
						end else begin
							phase_q <= PH_HEADER;
						end
					end
					PH_DATA: begin
						crc_q      <= crc16_byte(crc_q, b);
						byte_idx_q <= byte_idx_q + 1'b1;
						if (byte_idx_q == 7'h7f) begin
							phase_q <= PH_CRC_HI;
						end
					end
					PH_CRC_HI: begin
						phase_q <= PH_CRC_LO;
					end
					PH_CRC_LO: begin
						phase_q <= PH_HEADER;
						if (!crc_bad) begin
							exp_block_q <= exp_block_q + 1'b1;
						end
					end
					PH_DONE: ;
					default: phase_q <= PH_DONE;
				endcase
			end
		end
	end

`ifndef SYNTHESIS
	a_no_write_while_draining: assert property (@(posedge clk) disable iff (!arst_n)
		buf_wr.we |-> !flush_busy_q)
		else $error("buffer written while a flush is pending");
	a_flush_only_from_crc: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_cmd.is_flush) |-> phase_q == PH_CRC_LO)
		else $error("flush issued outside the crc phase");
	a_done_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |=> phase_q == PH_DONE)
		else $error("left the finished state");
`endif

endmodule

/* rtl/xcrc_back.sv */
module xcrc_back
	import xcrc_pkg::*;
#(
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  bufwr_t       buf_wr,
	input  cmd_t         head_cmd,
	input  logic         q_empty,
	output logic         pop,
	output logic         flush_done,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [87:0]  m_tdata,
	output logic         m_tuser,
	output logic         m_tlast
);

	localparam int EXT_W = (ADDR_BITS > 16) ? ADDR_BITS : 16;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WORD = 3'b010,
		S_ACK  = 3'b100
	} bstate_t;

	bstate_t               state_q;
	logic [WORD_IDX_W-1:0] k_q;
	logic [ADDR_BITS-1:0]  waddr_q;
	logic [WORD_W-1:0]     pkt_mem [WORDS];
	logic [WORD_W-1:0]     rdata_q;
	logic                  out_valid_q;
	logic [87:0]           out_data_q;
	logic                  out_kind_q;
	logic                  out_last_q;

	logic                  out_free;
	logic                  load_word;
	logic [WORD_IDX_W-1:0] rd_addr;
	logic [ADDR_BITS-1:0]  word_addr;
	logic [EXT_W-1:0]      word_addr_ext;

	assign out_free   = !out_valid_q || m_tready;
	assign pop        = (state_q == S_IDLE) && !q_empty && out_free;
	assign load_word  = (state_q == S_WORD) && out_free;
	assign flush_done = load_word && (k_q == WORD_IDX_W'(WORDS - 1));
	assign rd_addr    = (state_q != S_WORD) ? '0 : (load_word ? k_q + 1'b1 : k_q);

	assign word_addr     = waddr_q + ADDR_BITS'({k_q, 3'b000});
	assign word_addr_ext = EXT_W'(word_addr);

	always_ff @(posedge clk) begin
		if (buf_wr.we) begin
			pkt_mem[buf_wr.addr] <= buf_wr.data;
		end
		rdata_q <= pkt_mem[rd_addr];
	end

	// payload of the output register
	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= {64'd0, 16'd0, head_cmd.tx_byte};
			out_kind_q <= KIND_HOST;
			out_last_q <= 1'b1;
		end else if (load_word) begin
			out_data_q <= {rdata_q, word_addr_ext[15:0], 8'd0};
			out_kind_q <= KIND_WORD;
			out_last_q <= 1'b0;
		end else if (state_q == S_ACK && out_free) begin
			out_data_q <= {64'd0, 16'd0, CH_ACK};
			out_kind_q <= KIND_HOST;
			out_last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			waddr_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						out_valid_q <= !head_cmd.is_flush;
						if (head_cmd.is_flush) begin
							state_q <= S_WORD;
							k_q     <= '0;
						end
					end else if (m_tready) begin
						out_valid_q <= 1'b0;
					end
				end
				S_WORD: begin
					if (load_word) begin
						out_valid_q <= 1'b1;
						k_q         <= k_q + 1'b1;
						if (flush_done) begin
							state_q <= S_ACK;
						end
					end
				end
				S_ACK: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						waddr_q     <= waddr_q + ADDR_BITS'(PAYLOAD_BYTES);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_word_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_WORD) |-> !m_tlast)
		else $error("data word marked as last");
	a_index_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WORD && !out_free) |=> $stable(k_q) && $stable(rdata_q))
		else $error("buffer read moved during a stall");
	a_ack_after_last_word: assert property (@(posedge clk) disable iff (!arst_n)
		flush_done |=> state_q == S_ACK && m_tvalid && m_tuser == KIND_WORD)
		else $error("final word not followed by the acknowledge step");
`endif

endmodule

/* rtl/xmodem_crc_packet_receiver.sv */
// xmodem-crc receive side
// s_ channel: one word per received serial byte (tuser 0, byte in tdata) or per
//   time tick (tuser 1); ticks only matter before the first header, where a
//   'C' goes out every ready_interval ticks, the first tick after reset included
// m_ channel: bytes for the host (tuser 0: 'C', ACK or NAK in tdata[7:0]) and
//   verified data words (tuser 1: byte address in tdata[23:8], eight payload
//   bytes in tdata[87:24]); tlast marks the final word caused by one input word
// cfg port: register 0 crc_check_enable, register 1 ready_interval, written
//   only while the block is idle: a user rule, not enforced by the block
// an input word is taken while s_tready is high; a reply byte passes the command
//   queue into an output register, where it is held; a good packet gives sixteen
//   data words at one per cycle while the host side is ready, then the ACK; the
//   words are read from the 16 x 64 bit packet buffer over its single read port
// a two-entry command queue parts the byte parser from the output sequencer,
//   so input flows while the host stalls until the queue is full; else only the
//   first data byte of the next packet waits until the old buffer is read out
// reset (arst_n low) returns to waiting for the first header, block 1,
//   address 0, crc checking on, ready interval 65536; the buffer is not cleared
module xmodem_crc_packet_receiver
	import xcrc_pkg::*;
#(
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // rx_byte
	input  logic                  s_tuser,   // op
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [87:0]           m_tdata,   // tx_byte, word_address, data_word
	output logic                  m_tuser,   // kind
	output logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// front to queue
	logic   push;
	cmd_t   push_cmd;
	logic   q_full;

	// queue to back
	cmd_t   head_cmd;
	logic   q_empty;
	logic   pop;

	// buffer write path and release of the buffer
	bufwr_t buf_wr;
	logic   flush_done;

	xcrc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_full     (q_full),
		.push       (push),
		.push_cmd   (push_cmd),
		.buf_wr     (buf_wr),
		.flush_done (flush_done)
	);

	xcrc_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.empty    (q_empty),
		.full     (q_full)
	);

	xcrc_back #(
		.ADDR_BITS (ADDR_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.buf_wr     (buf_wr),
		.head_cmd   (head_cmd),
		.q_empty    (q_empty),
		.pop        (pop),
		.flush_done (flush_done),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule
